// File: hw/rtl/angle_weighted_vertex_normals_macros.svh
// Assertion macros shared by the angle-weighted vertex normal RTL.
`ifndef ANGLE_WEIGHTED_VERTEX_NORMALS_MACROS_SVH
`define ANGLE_WEIGHTED_VERTEX_NORMALS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AWVN_ASSERT_IMP(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AWVN_ASSERT_NXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: hw/rtl/awvn_pkg.sv
// Shared constants, types and tables of the angle-weighted vertex normal block.
`default_nettype none
package awvn_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int COORD_W      = 24;
  localparam int NORM_W       = 18;
  localparam int ACC_W        = 32;
  localparam int VEC_W        = 64;
  localparam int MUL_W        = 32;
  localparam int ROOT_W       = 32;
  localparam int QUOT_W       = 18;
  localparam int NUM_W        = 50;
  localparam int DEN_W        = ROOT_W + 1;
  localparam int CORD_W       = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int ANG_W        = 26;
  localparam int T_W          = 17;

  // pi in Q.24
  localparam logic [ANG_W-1:0] PI_Q24 = 26'd52707179;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TRI  = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  // atan(2^-i) in Q.24
  function automatic logic [23:0] atan_q24(input logic [STEP_W-1:0] step);
    logic [23:0] v;
    unique case (step)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/awvn_isqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
`default_nettype none
module awvn_isqrt import awvn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VEC_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic             busy_q, done_q;
  logic [VEC_W-1:0] rem_q, root_q, bit_q;
  logic [VEC_W-1:0] trial;

  assign trial  = root_q + bit_q;
  assign done_o = done_q;
  assign root_o = root_q[ROOT_W-1:0];

  // control: busy until the last bit pair is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // digit-by-digit root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rad_i;
      root_q <= '0;
      bit_q  <= VEC_W'(1) << (VEC_W - 2);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/awvn_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module awvn_div import awvn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [NUM_W-1:0]  rem_q, dsh_q;
  logic [QUOT_W-1:0] quot_q;

  assign done_o = done_q;
  assign quot_o = quot_q;

  // control: counts quotient bits from the top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(QUOT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // shift-subtract datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= NUM_W'(den_i) << (QUOT_W - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_q  <= rem_q - dsh_q;
        quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/awvn_cordic.sv
// Iterative CORDIC in vectoring mode, returns the angle of (x, y) in Q.24.
`default_nettype none
module awvn_cordic import awvn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  output logic                     done_o,
  output logic signed [CORD_W-1:0] z_o
);

  logic                     busy_q, done_q;
  logic [STEP_W-1:0]        i_q;
  logic signed [CORD_W-1:0] x_q, y_q, z_q;
  logic signed [CORD_W-1:0] xs, ys, at;

  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign at     = signed'(CORD_W'(atan_q24(i_q)));
  assign done_o = done_q;
  assign z_o    = z_q;

  // control: step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  // one micro-rotation per cycle, driving y toward zero
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= '0;
    end else if (busy_q) begin
      if (!y_q[CORD_W-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/angle_weighted_vertex_normals.sv
// Top level: vertex store, normal accumulators and the sequencer around one multiplier.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | req_type, coord_x/y/z, corner_a/b/c
//  out     | from block| out_valid_o / out_stall_i| normal_x/y/z, degenerate
//
// A load leaves the sequencer idle. The time of a read or a triangle is set by the
// 32-step square root and the 18-step divider, used several times per item, and
// by the 24-step CORDIC once per corner.
// A zero-area triangle ends once its cross product is known.
// Reset clears the sequencer and the output register only; vertex and
// accumulator memories hold nothing defined until loaded.
// A stalled result stays in the output register while the next item is taken.
`default_nettype none
`include "angle_weighted_vertex_normals_macros.svh"
module angle_weighted_vertex_normals import awvn_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic [IDX_W-1:0]          corner_a_i,
  input  logic [IDX_W-1:0]          corner_b_i,
  input  logic [IDX_W-1:0]          corner_c_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [NORM_W-1:0]  normal_x_o,
  output logic signed [NORM_W-1:0]  normal_y_o,
  output logic signed [NORM_W-1:0]  normal_z_o,
  output logic                      degenerate_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_TRI_RD, S_CROSS, S_TRI_NZ, S_EDGE1, S_EDGE2, S_DOT, S_WSQ,
    S_TSQRT, S_ASQ, S_XSQRT, S_CORD, S_ACC, S_RD_GET, S_RD_OUT,
    S_N_ABS, S_N_SHIFT, S_N_SQ, S_N_SQRT, S_N_DIVGO, S_N_DIVW
  } state_e;

  localparam int VROW_W = 3 * COORD_W;
  localparam int AROW_W = 3 * ACC_W;

  state_e                    state_q, ret_q;
  logic [2:0]                cnt_q;
  logic [1:0]                corner_q;
  logic [IDX_W-1:0]          idx_q [3];
  logic signed [COORD_W-1:0] vtx_q [3][3];
  logic signed [VEC_W-1:0]   vec_q [3];
  logic [VEC_W-1:0]          mag_q [3];
  logic                      sgn_q [3];
  logic [VEC_W-1:0]          acc_q;
  logic [ROOT_W-1:0]         len_q;
  logic signed [NORM_W-1:0]  nrm_q [3];
  logic signed [NORM_W-1:0]  fn_q [3];
  logic signed [NORM_W-1:0]  u_q [3];
  logic                      nz_q, dneg_q;
  logic [T_W-1:0]            t_q;
  logic [ANG_W-1:0]          ang_q;
  logic signed [ACC_W-1:0]   accw_q [3];
  logic signed [VEC_W-1:0]   prod_q;
  logic                      out_valid_q, degen_q;
  logic signed [NORM_W-1:0]  onrm_q [3];

  // memories
  logic [VROW_W-1:0] vmem_q [MAX_VERTICES];
  logic [AROW_W-1:0] amem_q [MAX_VERTICES];
  logic [VROW_W-1:0] vrd_q;
  logic [AROW_W-1:0] arow_q;

  logic              accept;
  logic              ok_a, ok_b, ok_c;
  logic [1:0]        ksel, kc, cp, cq, cr;
  logic signed [COORD_W:0] s1 [3];
  logic signed [COORD_W:0] s2 [3];
  logic signed [NORM_W:0]  w_v [3];
  logic signed [MUL_W-1:0] opa, opb;
  logic              any_hi, all_zero;
  logic              vm_we, am_we;
  logic [VIDX_W-1:0] vm_ra, am_ra, am_wa;
  logic [AROW_W-1:0] am_wd;
  logic              sq_start, sq_done;
  logic [VEC_W-1:0]  sq_rad;
  logic [ROOT_W-1:0] sq_root;
  logic              dv_start, dv_done;
  logic [NUM_W-1:0]  dv_num;
  logic [QUOT_W-1:0] dv_quot;
  logic              co_start, co_done;
  logic signed [CORD_W-1:0] co_x, co_y, co_z;
  logic signed [CORD_W+1:0] a2, a_raw, pi_ext;
  logic signed [VEC_W-1:0]  inc;
  logic signed [ACC_W+1:0]  asum;
  logic signed [ACC_W-1:0]  old_acc, acc_sat;
  logic signed [NORM_W-1:0] qs;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign degenerate_o = degen_q;
  assign normal_x_o  = onrm_q[0];
  assign normal_y_o  = onrm_q[1];
  assign normal_z_o  = onrm_q[2];

  assign ok_a = (32'(corner_a_i) < 32'(MAX_VERTICES));
  assign ok_b = (32'(corner_b_i) < 32'(MAX_VERTICES));
  assign ok_c = (32'(corner_c_i) < 32'(MAX_VERTICES));

  // lane selects: ksel issues, kc consumes the product of the previous cycle
  assign ksel = (cnt_q[1:0] == 2'd3) ? 2'd2 : cnt_q[1:0];
  assign kc   = (cnt_q[1:0] == 2'd0) ? 2'd0 : cnt_q[1:0] - 2'd1;

  // corner rotation: (a,b,c), (b,c,a), (c,a,b)
  always_comb begin
    unique case (corner_q)
      2'd1:    begin cp = 2'd1; cq = 2'd2; cr = 2'd0; end
      2'd2:    begin cp = 2'd2; cq = 2'd0; cr = 2'd1; end
      default: begin cp = 2'd0; cq = 2'd1; cr = 2'd2; end
    endcase
  end

  // triangle edges and half-angle difference or sum vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1[i]  = (COORD_W+1)'(vtx_q[1][i]) - (COORD_W+1)'(vtx_q[0][i]);
      s2[i]  = (COORD_W+1)'(vtx_q[2][i]) - (COORD_W+1)'(vtx_q[0][i]);
      w_v[i] = dneg_q ? (NORM_W+1)'(nrm_q[i]) + (NORM_W+1)'(u_q[i])
                      : (NORM_W+1)'(nrm_q[i]) - (NORM_W+1)'(u_q[i]);
    end
  end

  // shared multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_q)
      S_CROSS: begin
        unique case (cnt_q)
          3'd0:    begin opa = MUL_W'(s1[1]); opb = MUL_W'(s2[2]); end
          3'd1:    begin opa = MUL_W'(s1[2]); opb = MUL_W'(s2[1]); end
          3'd2:    begin opa = MUL_W'(s1[2]); opb = MUL_W'(s2[0]); end
          3'd3:    begin opa = MUL_W'(s1[0]); opb = MUL_W'(s2[2]); end
          3'd4:    begin opa = MUL_W'(s1[0]); opb = MUL_W'(s2[1]); end
          3'd5:    begin opa = MUL_W'(s1[1]); opb = MUL_W'(s2[0]); end
          default: ;
        endcase
      end
      S_N_SQ: begin
        opa = signed'({1'b0, mag_q[ksel][30:0]});
        opb = signed'({1'b0, mag_q[ksel][30:0]});
      end
      S_DOT: begin
        opa = MUL_W'(u_q[ksel]);
        opb = MUL_W'(nrm_q[ksel]);
      end
      S_WSQ: begin
        opa = MUL_W'(w_v[ksel]);
        opb = MUL_W'(w_v[ksel]);
      end
      S_ASQ: begin
        opa = signed'({7'b0, t_q, 8'b0});
        opb = signed'({7'b0, t_q, 8'b0});
      end
      S_ACC: begin
        opa = MUL_W'(fn_q[ksel]);
        opb = signed'({6'b0, ang_q});
      end
      default: ;
    endcase
  end

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
  end

  // magnitude range checks for the normalizer
  assign any_hi   = |{mag_q[0][VEC_W-1:31], mag_q[1][VEC_W-1:31], mag_q[2][VEC_W-1:31]};
  assign all_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);

  // unit hookup
  assign sq_start = ((state_q == S_N_SQ || state_q == S_WSQ) && cnt_q == 3'd4) ||
                    (state_q == S_ASQ && cnt_q == 3'd1);
  assign sq_rad   = (state_q == S_ASQ) ? (VEC_W'(1) << 48) - VEC_W'(prod_q) : acc_q;
  assign dv_start = (state_q == S_N_DIVGO);
  assign dv_num   = NUM_W'({mag_q[ksel][30:0], 17'b0}) + NUM_W'(len_q);
  assign co_start = (state_q == S_XSQRT) && sq_done;
  assign co_x     = signed'(CORD_W'(sq_root));
  assign co_y     = signed'({7'b0, t_q, 8'b0});
  assign qs       = signed'(dv_quot);

  awvn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  awvn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   ({len_q, 1'b0}),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  awvn_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (co_start),
    .x_i     (co_x),
    .y_i     (co_y),
    .done_o  (co_done),
    .z_o     (co_z)
  );

  // corner angle: 2*asin, mirrored for obtuse corners, limited to [0, pi]
  assign pi_ext = (CORD_W+2)'(signed'({1'b0, PI_Q24}));
  assign a2     = (CORD_W+2)'(co_z) <<< 1;
  assign a_raw  = dneg_q ? pi_ext - a2 : a2;

  // rounded weighted add with saturation
  assign old_acc = signed'(arow_q[ACC_W*kc +: ACC_W]);
  assign inc     = (prod_q + 64'sd8388608) >>> 24;
  assign asum    = (ACC_W+2)'(old_acc) + (ACC_W+2)'(inc);
  always_comb begin
    if (asum[ACC_W+1:ACC_W-1] == 3'b000 || asum[ACC_W+1:ACC_W-1] == 3'b111) begin
      acc_sat = asum[ACC_W-1:0];
    end else if (!asum[ACC_W+1]) begin
      acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end
  end

  // memory port control
  assign vm_we = accept && (req_type_i == REQ_LOAD) && ok_a;
  assign vm_ra = VIDX_W'(idx_q[ksel]);
  assign am_we = vm_we || (state_q == S_ACC && cnt_q == 3'd4);
  assign am_wa = (state_q == S_IDLE) ? VIDX_W'(corner_a_i) : VIDX_W'(idx_q[cp]);
  assign am_wd = (state_q == S_IDLE) ? '0 : {accw_q[2], accw_q[1], accw_q[0]};
  assign am_ra = (state_q == S_IDLE) ? VIDX_W'(corner_a_i) : VIDX_W'(idx_q[cp]);

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmem_q[VIDX_W'(corner_a_i)] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    vrd_q <= vmem_q[vm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (am_we) begin
      amem_q[am_wa] <= am_wd;
    end
    arow_q <= amem_q[am_ra];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      corner_q    <= '0;
      idx_q       <= '{default: '0};
      vtx_q       <= '{default: '{default: '0}};
      vec_q       <= '{default: '0};
      mag_q       <= '{default: '0};
      sgn_q       <= '{default: 1'b0};
      acc_q       <= '0;
      len_q       <= '0;
      nrm_q       <= '{default: '0};
      fn_q        <= '{default: '0};
      u_q         <= '{default: '0};
      nz_q        <= 1'b0;
      dneg_q      <= 1'b0;
      t_q         <= '0;
      ang_q       <= '0;
      accw_q      <= '{default: '0};
      out_valid_q <= 1'b0;
      degen_q     <= 1'b0;
      onrm_q      <= '{default: '0};
    end else begin
      // result taken; the output state refills the register itself
      if (out_valid_q && !out_stall_i && state_q != S_RD_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q[0] <= corner_a_i;
            idx_q[1] <= corner_b_i;
            idx_q[2] <= corner_c_i;
            corner_q <= '0;
            cnt_q    <= '0;
            if (req_type_i == REQ_TRI && ok_a && ok_b && ok_c) begin
              state_q <= S_TRI_RD;
            end else if (req_type_i == REQ_READ) begin
              if (ok_a) begin
                state_q <= S_RD_GET;
              end else begin
                nz_q    <= 1'b0;
                nrm_q   <= '{default: '0};
                state_q <= S_RD_OUT;
              end
            end
          end
        end
        // three vertex reads through the registered read port
        S_TRI_RD: begin
          if (cnt_q != 3'd0) begin
            vtx_q[kc][0] <= signed'(vrd_q[COORD_W-1:0]);
            vtx_q[kc][1] <= signed'(vrd_q[2*COORD_W-1:COORD_W]);
            vtx_q[kc][2] <= signed'(vrd_q[3*COORD_W-1:2*COORD_W]);
          end
          if (cnt_q == 3'd3) begin
            cnt_q   <= '0;
            state_q <= S_CROSS;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        // face normal, six products
        S_CROSS: begin
          cnt_q <= cnt_q + 1'b1;
          unique case (cnt_q)
            3'd1: vec_q[0] <= prod_q;
            3'd2: vec_q[0] <= vec_q[0] - prod_q;
            3'd3: vec_q[1] <= prod_q;
            3'd4: vec_q[1] <= vec_q[1] - prod_q;
            3'd5: vec_q[2] <= prod_q;
            3'd6: begin
              vec_q[2] <= vec_q[2] - prod_q;
              ret_q    <= S_TRI_NZ;
              state_q  <= S_N_ABS;
            end
            default: ;
          endcase
        end
        S_TRI_NZ: begin
          if (!nz_q) begin
            state_q <= S_IDLE;
          end else begin
            fn_q     <= nrm_q;
            corner_q <= '0;
            state_q  <= S_EDGE1;
          end
        end
        S_EDGE1: begin
          for (int i = 0; i < 3; i++) begin
            vec_q[i] <= VEC_W'(vtx_q[cq][i]) - VEC_W'(vtx_q[cp][i]);
          end
          ret_q   <= S_EDGE2;
          state_q <= S_N_ABS;
        end
        S_EDGE2: begin
          u_q <= nrm_q;
          for (int i = 0; i < 3; i++) begin
            vec_q[i] <= VEC_W'(vtx_q[cr][i]) - VEC_W'(vtx_q[cp][i]);
          end
          ret_q   <= S_DOT;
          state_q <= S_N_ABS;
        end
        // dot product of the unit edges
        S_DOT: begin
          if (cnt_q == 3'd4) begin
            dneg_q  <= acc_q[VEC_W-1];
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_WSQ;
          end else begin
            if (cnt_q != 3'd0) begin
              acc_q <= acc_q + VEC_W'(prod_q);
            end
            cnt_q <= cnt_q + 1'b1;
          end
        end
        // squared length of the difference or sum vector
        S_WSQ: begin
          if (cnt_q == 3'd4) begin
            state_q <= S_TSQRT;
          end else begin
            if (cnt_q != 3'd0) begin
              acc_q <= acc_q + VEC_W'(prod_q);
            end
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_TSQRT: begin
          if (sq_done) begin
            if (sq_root[ROOT_W-1:1] > (ROOT_W-1)'(65536)) begin
              t_q <= T_W'(65536);
            end else begin
              t_q <= sq_root[T_W:1];
            end
            cnt_q   <= '0;
            state_q <= S_ASQ;
          end
        end
        // cosine leg: sqrt(1 - t^2) in Q.24
        S_ASQ: begin
          if (cnt_q == 3'd1) begin
            state_q <= S_XSQRT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_XSQRT: begin
          if (sq_done) begin
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (co_done) begin
            if (a_raw < 0) begin
              ang_q <= '0;
            end else if (a_raw > pi_ext) begin
              ang_q <= PI_Q24;
            end else begin
              ang_q <= a_raw[ANG_W-1:0];
            end
            cnt_q   <= '0;
            state_q <= S_ACC;
          end
        end
        // weighted accumulate into corner p, written back at the end
        S_ACC: begin
          if (cnt_q == 3'd4) begin
            cnt_q <= '0;
            if (corner_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              corner_q <= corner_q + 1'b1;
              state_q  <= S_EDGE1;
            end
          end else begin
            if (cnt_q != 3'd0) begin
              accw_q[kc] <= acc_sat;
            end
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_RD_GET: begin
          for (int i = 0; i < 3; i++) begin
            vec_q[i] <= VEC_W'(signed'(arow_q[ACC_W*i +: ACC_W]));
          end
          ret_q   <= S_RD_OUT;
          state_q <= S_N_ABS;
        end
        S_RD_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            onrm_q      <= nrm_q;
            degen_q     <= !nz_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        // normalizer subroutine: vec_q -> nrm_q, nz_q, then back to ret_q
        S_N_ABS: begin
          for (int i = 0; i < 3; i++) begin
            sgn_q[i] <= vec_q[i][VEC_W-1];
            mag_q[i] <= vec_q[i][VEC_W-1] ? VEC_W'(-vec_q[i]) : VEC_W'(vec_q[i]);
          end
          state_q <= S_N_SHIFT;
        end
        S_N_SHIFT: begin
          acc_q <= '0;
          cnt_q <= '0;
          if (any_hi) begin
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_q[i] >> 1;
            end
          end else if (all_zero) begin
            nz_q    <= 1'b0;
            nrm_q   <= '{default: '0};
            state_q <= ret_q;
          end else begin
            state_q <= S_N_SQ;
          end
        end
        S_N_SQ: begin
          if (cnt_q == 3'd4) begin
            state_q <= S_N_SQRT;
          end else begin
            if (cnt_q != 3'd0) begin
              acc_q <= acc_q + VEC_W'(prod_q);
            end
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_N_SQRT: begin
          if (sq_done) begin
            len_q   <= sq_root;
            cnt_q   <= '0;
            state_q <= S_N_DIVGO;
          end
        end
        S_N_DIVGO: begin
          state_q <= S_N_DIVW;
        end
        S_N_DIVW: begin
          if (dv_done) begin
            nrm_q[ksel] <= sgn_q[ksel] ? -qs : qs;
            if (cnt_q == 3'd2) begin
              nz_q    <= 1'b1;
              cnt_q   <= '0;
              acc_q   <= '0;
              state_q <= ret_q;
            end else begin
              cnt_q   <= cnt_q + 1'b1;
              state_q <= S_N_DIVGO;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `AWVN_ASSERT_IMP(a_out_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_RD_OUT, "result raised outside the output state")
  `AWVN_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o, normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0, "degenerate result with nonzero normal")
  `AWVN_ASSERT_IMP(a_mag_range, clk_i, rst_ni, state_q == S_N_SQ, mag_q[0][VEC_W-1:31] == '0 && mag_q[1][VEC_W-1:31] == '0 && mag_q[2][VEC_W-1:31] == '0, "normalizer squared an unreduced magnitude")
  `AWVN_ASSERT_NXT(a_load_done, clk_i, rst_ni, accept && req_type_i == REQ_LOAD, state_q == S_IDLE, "load left the sequencer busy")

endmodule
`default_nettype wire
